FILE: rtl/xcfp_pkg.sv
`default_nettype none

package xcfp_pkg;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_CMD  = 3'd1,
        PH_LEN  = 3'd2,
        PH_DATA = 3'd3,
        PH_CKHI = 3'd4,
        PH_CKLO = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_DATA   = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    localparam int FIELD_LEN_W = 32;
    localparam int TDATA_W     = 56;
    localparam int Q_DEPTH     = 2;
    localparam int Q_AW        = 1;

    typedef struct packed {
        t_kind                   kind;
        logic [7:0]              command;
        logic [FIELD_LEN_W-1:0]  length;
        logic [7:0]              data;
        logic                    ok;
        logic                    last;
    } t_item;

endpackage

`default_nettype wire

FILE: rtl/xcfp_parser.sv
`default_nettype none

module xcfp_parser
    import xcfp_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_take,
    input  wire logic [7:0]  i_byte,
    output logic             o_push,
    output t_item            o_item
);

    t_phase                  r_phase, n_phase;
    logic [15:0]             r_mark;
    logic [7:0]              r_prev, n_prev;
    logic                    r_prev_valid, n_prev_valid;
    logic [7:0]              r_cmd, n_cmd;
    logic [FIELD_LEN_W-1:0]  r_len_acc, n_len_acc;
    logic [LENGTH_BITS-1:0]  r_frame_len, n_frame_len;
    logic [LENGTH_BITS-1:0]  r_left, n_left;
    logic [1:0]              r_len_idx, n_len_idx;
    logic [7:0]              r_xor, n_xor;
    logic [7:0]              r_ckhi, n_ckhi;
    logic [FIELD_LEN_W-1:0]  w_len_full;

    assign w_len_full = {r_len_acc[FIELD_LEN_W-9:0], i_byte};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_prev_valid <= 1'b0;
            r_mark       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_mark <= i_cfg_data;
            end
            if (i_take) begin
                r_phase      <= n_phase;
                r_prev_valid <= n_prev_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_take) begin
            r_prev      <= n_prev;
            r_cmd       <= n_cmd;
            r_len_acc   <= n_len_acc;
            r_frame_len <= n_frame_len;
            r_left      <= n_left;
            r_len_idx   <= n_len_idx;
            r_xor       <= n_xor;
            r_ckhi      <= n_ckhi;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_prev       = r_prev;
        n_prev_valid = r_prev_valid;
        n_cmd        = r_cmd;
        n_len_acc    = r_len_acc;
        n_frame_len  = r_frame_len;
        n_left       = r_left;
        n_len_idx    = r_len_idx;
        n_xor        = r_xor;
        n_ckhi       = r_ckhi;
        o_push       = 1'b0;
        o_item.kind  = KIND_HEADER;
        o_item.data  = '0;
        o_item.ok    = 1'b0;
        o_item.last  = 1'b0;

        unique case (r_phase)
            PH_CMD: begin
                n_cmd     = i_byte;
                n_xor     = r_xor ^ i_byte;
                n_len_acc = '0;
                n_len_idx = '0;
                n_phase   = PH_LEN;
            end
            PH_LEN: begin
                n_len_acc = w_len_full;
                n_xor     = r_xor ^ i_byte;
                n_len_idx = r_len_idx + 2'd1;
                if (r_len_idx == 2'd3) begin
                    if ((w_len_full >> LENGTH_BITS) != '0) begin
                        n_frame_len = '1;
                    end else begin
                        n_frame_len = w_len_full[LENGTH_BITS-1:0];
                    end
                    n_left      = n_frame_len;
                    n_phase     = (n_frame_len != '0) ? PH_DATA : PH_CKHI;
                    o_push      = i_take;
                    o_item.kind = KIND_HEADER;
                end
            end
            PH_DATA: begin
                n_xor  = r_xor ^ i_byte;
                n_left = r_left - LENGTH_BITS'(1);
                if (r_left == LENGTH_BITS'(1)) begin
                    n_phase = PH_CKHI;
                end
                o_push      = i_take;
                o_item.kind = KIND_DATA;
                o_item.data = i_byte;
            end
            PH_CKHI: begin
                n_ckhi  = i_byte;
                n_phase = PH_CKLO;
            end
            PH_CKLO: begin
                n_phase      = PH_HUNT;
                n_prev_valid = 1'b0;
                o_push       = i_take;
                o_item.kind  = KIND_END;
                o_item.ok    = (r_ckhi == 8'd0) && (i_byte == r_xor);
                o_item.last  = 1'b1;
            end
            default: begin
                if (r_prev_valid && ({r_prev, i_byte} == r_mark)) begin
                    n_xor        = r_prev ^ i_byte;
                    n_prev_valid = 1'b0;
                    n_phase      = PH_CMD;
                end else begin
                    n_prev       = i_byte;
                    n_prev_valid = 1'b1;
                    n_phase      = PH_HUNT;
                end
            end
        endcase

        o_item.command = n_cmd;
        o_item.length  = FIELD_LEN_W'(n_frame_len);
    end

endmodule

`default_nettype wire

FILE: rtl/xcfp_queue.sv
`default_nettype none

module xcfp_queue
    import xcfp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    input  wire logic  i_pop,
    output logic       o_full,
    output logic       o_valid,
    output t_item      o_item
);

    t_item             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr, r_rd;
    logic [Q_AW:0]     r_count;

    assign o_full  = (r_count == (Q_AW+1)'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            r_count <= r_count + (Q_AW+1)'(i_push) - (Q_AW+1)'(i_pop);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/xcfp_outreg.sv
`default_nettype none

module xcfp_outreg
    import xcfp_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    input  wire t_item i_item,
    output logic       o_pop,
    input  wire logic  i_ready,
    output logic       o_valid,
    output t_item      o_item
);

    logic r_valid;
    t_item r_item;

    assign o_pop   = i_valid && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/xor_checked_frame_parser_top.sv
// Frame parser for a received byte stream: hunts for the 16-bit start mark
// (high byte first), then reads a command byte, a 4-byte big-endian length,
// the payload and a 16-bit checksum (XOR of all earlier frame bytes, so the
// high byte must be zero). Emits a header beat, one beat per payload byte and
// an end beat with tlast and the verdict; drop the frame downstream on a bad
// verdict. One byte is taken every cycle while the queue is not full. The
// parser state machine feeds a two-entry queue and then an output register,
// through which each result reaches the master side. The input stalls only
// once the queue is full behind a stalled output. LENGTH_BITS sets the length
// counter width; wider declared lengths saturate.
`default_nettype none

module xor_checked_frame_parser_top
    import xcfp_pkg::*;
#(
    parameter int LENGTH_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_data,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // byte_value
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,   // command, payload_length, data_byte,
                                                    // checksum_ok, zero fill
    output logic [1:0]              m_axis_tuser,   // item_kind
    output logic                    m_axis_tlast    // last
);

    logic  w_take, w_push, w_full, w_q_valid, w_pop;
    t_item w_p_item, w_q_item, w_o_item;

    assign s_axis_tready = !w_full;
    assign w_take        = s_axis_tvalid && !w_full;

    xcfp_parser #(
        .LENGTH_BITS(LENGTH_BITS)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_take     (w_take),
        .i_byte     (s_axis_tdata),
        .o_push     (w_push),
        .o_item     (w_p_item)
    );

    xcfp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_p_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    xcfp_outreg u_outreg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_q_valid),
        .i_item  (w_q_item),
        .o_pop   (w_pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_item  (w_o_item)
    );

    assign m_axis_tdata = {7'd0, w_o_item.ok, w_o_item.data, w_o_item.length,
                           w_o_item.command};
    assign m_axis_tuser = w_o_item.kind;
    assign m_axis_tlast = w_o_item.last;

endmodule

`default_nettype wire

FILE: rtl/xcfp_checker.sv
`default_nettype none

module xcfp_assert
    import xcfp_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               m_axis_tvalid,
    input wire logic               m_axis_tready,
    input wire logic [TDATA_W-1:0] m_axis_tdata,
    input wire logic [1:0]         m_axis_tuser,
    input wire logic               m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("master beat changed while stalled");

    a_last_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser == KIND_END)))
        else $error("tlast does not match end beat");

    a_ok_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !m_axis_tdata[48])
        else $error("verdict set outside end beat");

    a_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser != KIND_DATA) |-> (m_axis_tdata[47:40] == 8'd0))
        else $error("data byte nonzero outside payload beat");

endmodule

bind xor_checked_frame_parser_top xcfp_assert u_xcfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
